/* sv/amed_pkg.sv */
// Package: widths, register codes, reset values and shared types of the AM envelope detector.
package amed_pkg;

    // Field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int ENV_W     = SAMPLE_W - 1;
    localparam int DECAY_W   = 16;
    localparam int DECIM_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Moving average ring
    localparam int MA_LEN = 1000;
    localparam int POS_W  = $clog2(MA_LEN);
    localparam int SUM_W  = ENV_W + POS_W;
    localparam logic [POS_W-1:0] RING_LAST = POS_W'(MA_LEN - 1);

    // Divide by MA_LEN as multiply by a rounded-up reciprocal; exact for every sum
    localparam int AVG_SHIFT = SUM_W + POS_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam longint unsigned AVG_RECIP_L =
        ((longint'(1) << AVG_SHIFT) + longint'(MA_LEN) - 1) / longint'(MA_LEN);
    localparam logic [RECIP_W-1:0] AVG_RECIP = AVG_RECIP_L[RECIP_W-1:0];

    // Output bus packing
    localparam int OUT_BITS = SAMPLE_W + ENV_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Register reset values
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(65503);
    localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(109);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY = 1'b0,
        CFG_DECIM = 1'b1
    } cfg_idx_t;

    // Live configuration handed to the datapath
    typedef struct packed {
        logic [DECAY_W-1:0] decay;
        logic [DECIM_W-1:0] terminal;
    } cfg_t;

    // Decimated envelope item between the envelope and averaging stages
    typedef struct packed {
        logic             valid;
        logic [ENV_W-1:0] env;
    } env_item_t;

endpackage

/* sv/amed_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module amed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/amed_env.sv */
// Peak envelope with Q0.16 decay and the decimation counter; passes emitted envelopes on.
module amed_env (
    input  logic                              clk,
    input  logic                              rst_n,
    input  amed_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    input  logic signed [amed_pkg::SAMPLE_W-1:0] in_sample,
    output logic                              in_ready,
    output amed_pkg::env_item_t               out_item,
    input  logic                              out_ready
);
    import amed_pkg::*;

    logic [ENV_W-1:0]         env_reg, env_next;
    logic [DECIM_W-1:0]       cnt_reg, cnt_next;
    logic                     valid_reg, valid_next;
    logic [ENV_W-1:0]         emit_env_reg, emit_env_next;
    logic                     take;
    logic                     larger;
    logic                     emit;
    logic [ENV_W-1:0]         peak;
    logic [ENV_W+DECAY_W-1:0] prod;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Peak capture then decay; loop closes through env_reg
    always_comb
    begin
        larger   = in_sample > $signed({1'b0, env_reg});
        peak     = larger ? in_sample[ENV_W-1:0] : env_reg;
        prod     = {{DECAY_W{1'b0}}, peak} * {{ENV_W{1'b0}}, cfg.decay};
        env_next = take ? prod[DECAY_W +: ENV_W] : env_reg;
    end

    // Decimation counter, wraps at 8 bits when the terminal is skipped
    always_comb
    begin
        emit = (cnt_reg == cfg.terminal);
        if (!take)
        begin
            cnt_next = cnt_reg;
        end
        else if (emit)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + DECIM_W'(1);
        end
    end

    // Emitted item register; items that emit nothing leave no bubble behind
    always_comb
    begin
        if (take)
        begin
            valid_next = emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
        emit_env_next = (take && emit) ? env_next : emit_env_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            env_reg   <= env_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_env_reg <= emit_env_next;
    end

    assign out_item.valid = valid_reg;
    assign out_item.env   = emit_env_reg;

    // Counter restarts after every emitting item
    a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> (cnt_reg == '0))
        else $error("decimation counter did not restart after emission");

    // Envelope never grows unless a larger sample arrives
    a_env_decays: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !larger) |=> (env_reg <= $past(env_reg)))
        else $error("envelope grew without a larger sample");

    // Emitted item carries the envelope just computed
    a_emit_env: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit) |=> (valid_reg && emit_env_reg == env_reg))
        else $error("emitted envelope differs from envelope state");

endmodule

/* sv/amed_avg.sv */
// Moving average ring, running sum, constant divide and DC removal; holds the result register.
module amed_avg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  amed_pkg::env_item_t               in_item,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [amed_pkg::SAMPLE_W-1:0] out_audio,
    output logic [amed_pkg::ENV_W-1:0]        out_env
);
    import amed_pkg::*;

    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     wrapped_reg, wrapped_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     s3_valid_reg, s3_valid_next;
    logic [ENV_W-1:0]         s3_env_reg, s3_env_next;
    logic                     o_valid_reg, o_valid_next;
    logic [SAMPLE_W-1:0]      o_audio_reg, o_audio_next;
    logic [ENV_W-1:0]         o_env_reg, o_env_next;
    logic                     take_in;
    logic                     s3_ready;
    logic                     s3_move;
    logic [ENV_W-1:0]         rd_data;
    logic [ENV_W-1:0]         old_val;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [ENV_W-1:0]         avg;

    assign s3_ready = !o_valid_reg || out_ready;
    assign in_ready = !s3_valid_reg || s3_ready;
    assign take_in  = in_item.valid && in_ready;
    assign s3_move  = s3_valid_reg && s3_ready;

    // Ring storage; read port always fetches the slot that the next write replaces
    amed_ram #(
        .WIDTH (ENV_W),
        .DEPTH (MA_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (take_in),
        .waddr (pos_reg),
        .wdata (in_item.env),
        .raddr (pos_next),
        .rdata (rd_data)
    );

    // Ring pointer and running sum; slots not yet written count as zero
    always_comb
    begin
        old_val      = wrapped_reg ? rd_data : '0;
        pos_next     = pos_reg;
        wrapped_next = wrapped_reg;
        sum_next     = sum_reg;
        if (take_in)
        begin
            sum_next = sum_reg - {{POS_W{1'b0}}, old_val} + {{POS_W{1'b0}}, in_item.env};
            if (pos_reg == RING_LAST)
            begin
                pos_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Ring stage item holder
    always_comb
    begin
        if (take_in)
        begin
            s3_valid_next = 1'b1;
        end
        else if (s3_ready)
        begin
            s3_valid_next = 1'b0;
        end
        else
        begin
            s3_valid_next = s3_valid_reg;
        end
        s3_env_next = take_in ? in_item.env : s3_env_reg;
    end

    // Average by reciprocal multiply, then envelope minus average
    always_comb
    begin
        prod = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, AVG_RECIP};
        avg  = prod[AVG_SHIFT +: ENV_W];
        if (s3_move)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
        o_audio_next = s3_move ? ({1'b0, s3_env_reg} - {1'b0, avg}) : o_audio_reg;
        o_env_next   = s3_move ? s3_env_reg : o_env_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
            sum_reg      <= '0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            wrapped_reg  <= wrapped_next;
            sum_reg      <= sum_next;
            s3_valid_reg <= s3_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_env_reg  <= s3_env_next;
        o_audio_reg <= o_audio_next;
        o_env_reg   <= o_env_next;
    end

    assign out_valid = o_valid_reg;
    assign out_audio = o_audio_reg;
    assign out_env   = o_env_reg;

    // Running sum stays within a full ring of maximal envelopes
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(MA_LEN * ((1 << ENV_W) - 1)))
        else $error("running sum out of range");

    // Audio output never exceeds the envelope it goes with
    a_audio_le_env: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> ($signed(o_audio_reg) <= $signed({1'b0, o_env_reg})))
        else $error("audio exceeds envelope");

    // Every ring write moves the pointer
    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> (pos_reg != $past(pos_reg)))
        else $error("ring pointer did not advance");

endmodule

/* sv/am_envelope_detector_decimator_core.sv */
// Top level of the AM envelope detector with decimation and DC removal.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[15:0] sample
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata[15:0] audio, [30:16] envelope
//  cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One sample is taken every cycle unless a stalled output has backed up the pipeline;
// the envelope loop closes through one 15x16 multiply per cycle.
// A stalled output blocks only once the register stages behind it are full. Reset needs
// no clearing pass: ring slots not yet written count as zero. cfg_ready is always high;
// the user must change registers only while the block is idle; the block does not check.
module am_envelope_detector_decimator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [amed_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [amed_pkg::OUT_W-1:0]        m_axis_tdata,   // [15:0] audio, [30:16] envelope
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [amed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amed_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import amed_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0]  s1_sample_reg, s1_sample_next;
    logic                 env_in_ready;
    logic                 accept;
    env_item_t            env_item;
    logic                 avg_in_ready;
    logic [SAMPLE_W-1:0]  audio;
    logic [ENV_W-1:0]     envelope;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DECAY: cfg_next.decay    = cfg_data[DECAY_W-1:0];
                CFG_DECIM: cfg_next.terminal = cfg_data[DECIM_W-1:0];
            endcase
        end
    end

    // Input register
    assign s_axis_tready = !s1_valid_reg || env_in_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (env_in_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        s1_sample_next = accept ? s_axis_tdata : s1_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay    <= DECAY_RESET;
            cfg_reg.terminal <= DECIM_RESET;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= s1_sample_next;
    end

    // Envelope and decimation
    amed_env u_env (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s1_valid_reg),
        .in_sample ($signed(s1_sample_reg)),
        .in_ready  (env_in_ready),
        .out_item  (env_item),
        .out_ready (avg_in_ready)
    );

    // Moving average and DC removal
    amed_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (env_item),
        .in_ready  (avg_in_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_audio (audio),
        .out_env   (envelope)
    );

    assign m_axis_tdata = {{(OUT_W - OUT_BITS){1'b0}}, envelope, audio};

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the AM envelope detector and decimator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amed_pkg::*;

    localparam int SETTLE_CYCLES = 12;   // margin for the pipeline to drain
    localparam int HOLD_CYCLES   = 300;  // long output stall to back up the block

    // One expected result, in output field terms
    typedef struct packed {
        logic [ENV_W-1:0]    env;
        logic [SAMPLE_W-1:0] audio;
    } audio_item_t;

    // Envelope, decimation and moving average predictor plus result checker
    class amed_scoreboard;
        logic [DECAY_W-1:0] decay;
        logic [DECIM_W-1:0] terminal;
        logic [ENV_W-1:0]   peak;
        logic [DECIM_W-1:0] count;
        logic [ENV_W-1:0]   ring_env [MA_LEN];
        int unsigned        pos;
        logic [SUM_W-1:0]   sum;
        audio_item_t        audio_due [$];
        int unsigned        failures;
        int unsigned        samples_seen;
        int unsigned        results_seen;
        int unsigned        ring_laps;

        function new();
            decay    = DECAY_RESET;
            terminal = DECIM_RESET;
            peak     = '0;
            count    = '0;
            pos      = 0;
            sum      = '0;
            foreach (ring_env[i]) ring_env[i] = '0;
            failures     = 0;
            samples_seen = 0;
            results_seen = 0;
            ring_laps    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_DECAY: decay    = val[DECAY_W-1:0];
                CFG_DECIM: terminal = val[DECIM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return audio_due.size();
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // Peak capture, decay, decimation, then ring update and average
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            logic [ENV_W+DECAY_W-1:0] prod;
            logic [SUM_W-1:0]         avg;
            audio_item_t              r;
            samples_seen++;
            if (s > $signed({1'b0, peak}))
                peak = s[ENV_W-1:0];
            prod = peak * decay;
            peak = prod[ENV_W+DECAY_W-1:DECAY_W];
            if (count != terminal)
            begin
                count = count + 1'b1;
                return;
            end
            count = '0;
            sum = sum - ring_env[pos] + peak;
            ring_env[pos] = peak;
            if (pos == MA_LEN - 1)
            begin
                pos = 0;
                ring_laps++;
            end
            else
            begin
                pos++;
            end
            avg = sum / SUM_W'(MA_LEN);
            r.env   = peak;
            r.audio = {1'b0, peak} - avg[SAMPLE_W-1:0];
            audio_due.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] tdata);
            audio_item_t want;
            logic [SAMPLE_W-1:0] got_audio;
            logic [ENV_W-1:0]    got_env;
            got_audio = tdata[SAMPLE_W-1:0];
            got_env   = tdata[SAMPLE_W+ENV_W-1:SAMPLE_W];
            results_seen++;
            if (audio_due.size() == 0)
            begin
                flag($sformatf("result with nothing expected: audio %0d env %0d",
                               $signed(got_audio), got_env));
                return;
            end
            want = audio_due.pop_front();
            if (got_audio !== want.audio || got_env !== want.env)
                flag($sformatf("result %0d: audio exp %0d got %0d, env exp %0d got %0d",
                               results_seen, $signed(want.audio), $signed(got_audio),
                               want.env, got_env));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;    // [15:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;    // [15:0] audio, [30:16] envelope
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    amed_scoreboard sb;
    int unsigned    src_idle_pct;
    int unsigned    snk_stall_pct;
    bit             hold_req;
    int unsigned    reg_writes;

    am_envelope_detector_decimator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #5ms;
        $display("timeout: %0d results still due", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // Output side: random stalls, a long hold on request, check at rising edge
    initial
    begin
        int unsigned hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Offer one sample, with random idle gaps first; returns at a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    // Wait for every due result, then for the pipeline to empty
    task automatic settle();
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers back to back; only called while the block is idle
    task automatic write_config(input logic [DECAY_W-1:0] decay,
                                input logic [DECIM_W-1:0] terminal);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DECAY;
        cfg_data  <= decay;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(CFG_DECAY, decay);
        @(negedge clk);
        cfg_index <= CFG_DECIM;
        cfg_data  <= CFG_DAT_W'(terminal);
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(CFG_DECIM, CFG_DAT_W'(terminal));
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    // Change pacing between falling edges so the output side sees it cleanly
    task automatic set_pace(input int unsigned idle, input int unsigned stall);
        @(posedge clk);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        @(negedge clk);
    endtask

    // Mix of full-range noise, strong positive peaks, negatives and quiet stretches
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(32767, 8192));
            2: return SAMPLE_W'(-int'($urandom_range(32768, 1)));
            default: return SAMPLE_W'(int'($urandom_range(511)) - 256);
        endcase
    endfunction

    task automatic run_random(input int unsigned n);
        repeat (n) push_sample(rand_sample());
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] peaks [13];
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_DECAY;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b0;
        reg_writes    = 0;
        peaks = '{16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF,
                  16'h4000, 16'hC000, 16'h7FFE, 16'h5555, 16'hAAAA, 16'h0100, 16'h0000};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset register values: one result after 110 samples, counter back at zero
        run_random(110);
        settle();

        // Directed: field extremes with near-unity decay and every sample emitted
        write_config(16'hFFFF, 8'd0);
        foreach (peaks[i]) push_sample(peaks[i]);
        s_axis_tvalid <= 1'b0;
        settle();

        // Directed: zero decay flattens the envelope after every sample
        write_config(16'h0000, 8'd0);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0064);
        push_sample(16'h7FFF);
        s_axis_tvalid <= 1'b0;
        settle();

        // Back-to-back input with a long output hold so the block backs up
        write_config(16'hFFFF, 8'd0);
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        run_random(300);
        settle();

        // Sparse input, typical decay
        write_config(DECAY_W'($urandom_range(65535, 60000)), 8'd0);
        set_pace(63, 0);
        run_random(240);
        settle();

        // Heavy output stalls; enough emitted values to wrap the average ring
        write_config(DECAY_W'($urandom), 8'd0);
        set_pace(0, 63);
        run_random(480);
        settle();

        // Zero decay at a short period, both sides jittery
        write_config(16'h0000, 8'd2);
        set_pace(8, 8);
        run_random(30);
        settle();

        // Longest period, run only part way so the count builds up
        write_config(DECAY_W'($urandom_range(65535, 32768)), 8'd255);
        run_random(12);
        settle();

        // Terminal lowered below the running count: counter wraps before emitting
        write_config(DECAY_W'($urandom), 8'd2);
        set_pace(0, 0);
        run_random(250);
        settle();

        $display("sent %0d samples, checked %0d results over %0d register writes",
                 sb.samples_seen, sb.results_seen, reg_writes);
        $display("average ring wrapped %0d times; %0d mismatches",
                 sb.ring_laps, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* am_envelope_detector_decimator_core.f */
sv/amed_pkg.sv
sv/amed_ram.sv
sv/amed_env.sv
sv/amed_avg.sv
sv/am_envelope_detector_decimator_core.sv
verif/tb_top.sv
